[sv/jd2dt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package jd2dt_pkg;

    // input widths
    localparam int DAY_NUMBER_BITS = 23;
    localparam int MS_BITS         = 27;

    // day numbers that give years 0 through 9999 (0000-01-01 .. 9999-12-31)
    localparam logic [31:0] JDN_FIRST = 32'd1721060;
    localparam logic [31:0] JDN_LAST  = 32'd5373484;

    // date datapath widths, valid for day numbers inside the range above
    localparam int Z_BITS  = 23;
    localparam int N1_BITS = 24;

    // alpha + 8 = floor((4z - 6300089) / 146097), kept non-negative
    localparam logic [24:0] ALPHA_BIAS  = 25'd6300089;
    localparam logic [6:0]  ALPHA_RECIP = 7'd114;        // floor(2^24 / 146097)
    localparam logic [17:0] ALPHA_DIV   = 18'd146097;
    localparam logic [22:0] B_BIAS      = 23'd1519;

    // c = floor((20b - 2442) / 7305)
    localparam logic [26:0] C_BIAS      = 27'd2442;
    localparam logic [14:0] C_RECIP     = 15'd18373;     // floor(2^27 / 7305)
    localparam logic [12:0] C_DIV       = 13'd7305;
    localparam logic [10:0] D_MUL       = 11'd1461;

    // e = floor(10000 (b - d) / 306001)
    localparam logic [13:0] E_SCALE     = 14'd10000;
    localparam logic [4:0]  E_RECIP     = 5'd27;         // floor(2^23 / 306001)
    localparam logic [18:0] E_DIV       = 19'd306001;

    localparam logic [13:0] YEAR_OFS_LATE  = 14'd4716;
    localparam logic [13:0] YEAR_OFS_EARLY = 14'd4715;

    // time of day
    localparam logic [26:0] MS_PER_DAY    = 27'd86400000;
    localparam logic [5:0]  HOUR_RECIP    = 6'd37;       // floor(2^27 / 3600000)
    localparam logic [21:0] MS_PER_HOUR   = 22'd3600000;
    localparam logic [6:0]  MINUTE_RECIP  = 7'd69;       // floor(2^22 / 60000)
    localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
    localparam logic [6:0]  SECOND_RECIP  = 7'd65;       // floor(2^16 / 1000)
    localparam logic [9:0]  MS_PER_SECOND = 10'd1000;

    // pipeline depth before the output register
    localparam int STAGES = 15;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [9:0] millisecond;
    } tod_t;

    // floor(30.6001 * e), the day count of the months before month e
    function automatic logic [8:0] month_start(input logic [4:0] e);
        logic [8:0] v;
        case (e)
            5'd0:    v = 9'd0;
            5'd1:    v = 9'd30;
            5'd2:    v = 9'd61;
            5'd3:    v = 9'd91;
            5'd4:    v = 9'd122;
            5'd5:    v = 9'd153;
            5'd6:    v = 9'd183;
            5'd7:    v = 9'd214;
            5'd8:    v = 9'd244;
            5'd9:    v = 9'd275;
            5'd10:   v = 9'd306;
            5'd11:   v = 9'd336;
            5'd12:   v = 9'd367;
            5'd13:   v = 9'd397;
            5'd14:   v = 9'd428;
            5'd15:   v = 9'd459;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[sv/julian_day_to_date_time_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   handshake          payload
// -------   ----------------   ---------------------------------------------------
// item in   start / busy       day_number, millisecond_of_day
// item out  done (1-cycle)     year, month, day_of_month, hour, minute, second,
//                              millisecond, in_range
//
// one item per cycle: fifteen register stages plus the output register, each
// holding mostly one constant multiply or one subtract, compare and correct
// busy stays low; every stage moves forward every cycle and the receiver cannot stall
// reset clears only the valid and done bits; the datapath registers are not reset
// out-of-range years are found by comparing the day number with fixed bounds

module julian_day_to_date_time_core
    import jd2dt_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [DAY_NUMBER_BITS-1:0] day_number,
    input  wire logic [MS_BITS-1:0]         millisecond_of_day,
    output logic                            done,
    output logic [13:0]                     year,
    output logic [3:0]                      month,
    output logic [4:0]                      day_of_month,
    output logic [4:0]                      hour,
    output logic [5:0]                      minute,
    output logic [5:0]                      second,
    output logic [9:0]                      millisecond,
    output logic                            in_range
);

    // valid and in-range flags travel with the item
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] ok_reg;
    logic              done_reg;

    // ---------------- date path registers (stage numbers in comments) ----------------
    logic [Z_BITS-1:0]  z_reg   [4];     // s1..s4
    logic [N1_BITS-1:0] n1_reg  [3];     // s1..s3
    logic [6:0]         q1e_reg [2];     // s2..s3
    logic [N1_BITS-1:0] t1_reg;          // s3
    logic [6:0]         alpha8_reg;      // s4
    logic [22:0]        b_reg   [6];     // s5..s10
    logic [26:0]        n2_reg  [3];     // s6..s8
    logic [13:0]        q2e_reg [2];     // s7..s8
    logic [26:0]        t2_reg;          // s8
    logic [13:0]        c_reg   [7];     // s9..s15
    logic [22:0]        d_reg;           // s10
    logic [8:0]         bd_reg  [5];     // s11..s15
    logic [22:0]        n4_reg  [3];     // s12..s14
    logic [4:0]         q4e_reg [2];     // s13..s14
    logic [23:0]        t4_reg;          // s14
    logic [4:0]         e_reg;           // s15

    // ---------------- time path registers ----------------
    logic [MS_BITS-1:0] ms_reg  [3];     // s1..s3
    logic [4:0]         hq_reg  [2];     // s2..s3
    logic [26:0]        th_reg;          // s3
    logic [4:0]         hour_reg [6];    // s4..s9
    logic [21:0]        rh_reg  [3];     // s4..s6
    logic [5:0]         mq_reg  [2];     // s5..s6
    logic [21:0]        tm_reg;          // s6
    logic [5:0]         minute_reg [3];  // s7..s9
    logic [15:0]        rm_reg  [3];     // s7..s9
    logic [5:0]         sq_reg  [2];     // s8..s9
    logic [15:0]        ts_reg;          // s9
    tod_t               tod_reg [6];     // s10..s15

    // ---------------- output registers ----------------
    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    tod_t        tod_out_reg;
    logic        in_range_reg;

    // ---------------- next values ----------------
    logic [31:0]              z_ext;
    logic                     ok_next;
    logic [Z_BITS-1:0]        z_next;
    logic [N1_BITS-1:0]       n1_next;
    logic [MS_BITS-1:0]       ms_next;

    logic [N1_BITS+6:0]       q1_prod;
    logic [6:0]               q1e_next;
    logic [24:0]              t1_full;
    logic [N1_BITS-1:0]       t1_next;
    logic [N1_BITS-1:0]       r1;
    logic [6:0]               alpha8_next;
    logic [22:0]              b_next;
    logic [26:0]              n2_next;
    logic [41:0]              q2_prod;
    logic [13:0]              q2e_next;
    logic [26:0]              t2_next;
    logic [26:0]              r2;
    logic [13:0]              c_next;
    logic [24:0]              d_full;
    logic [22:0]              d_next;
    logic [8:0]               bd_next;
    logic [22:0]              n4_next;
    logic [27:0]              q4_prod;
    logic [4:0]               q4e_next;
    logic [23:0]              t4_next;
    logic [23:0]              r4;
    logic [4:0]               e_next;

    logic [4:0]               day_next;
    logic [3:0]               month_next;
    logic [13:0]              year_next;

    logic [32:0]              hq_prod;
    logic [4:0]               hq_next;
    logic [26:0]              th_next;
    logic [26:0]              rh_raw;
    logic                     rh_fix;
    logic [4:0]               hour_next;
    logic [21:0]              rh_next;
    logic [28:0]              mq_prod;
    logic [5:0]               mq_next;
    logic [21:0]              tm_next;
    logic [21:0]              rm_raw;
    logic                     rm_fix;
    logic [5:0]               minute_next;
    logic [15:0]              rm_next;
    logic [22:0]              sq_prod;
    logic [5:0]               sq_next;
    logic [15:0]              ts_next;
    logic [15:0]              rs_raw;
    logic                     rs_fix;
    tod_t                     tod_next;

    // alpha - floor(alpha / 4) term, expressed with the biased alpha (alpha + 8)
    function automatic logic [6:0] alpha8_next_hold(input logic [6:0] a8);
        return a8 - 7'(a8[6:2]);
    endfunction

    // ---------------- s1: range check, bias, saturate ----------------
    always_comb
    begin
        z_ext   = 32'(day_number);
        ok_next = (z_ext >= JDN_FIRST) && (z_ext <= JDN_LAST);
        z_next  = z_ext[Z_BITS-1:0];
        // 4z shifted up by eight 400-year cycles so the quotient never goes negative
        n1_next = N1_BITS'({z_next, 2'b00} - ALPHA_BIAS);
        ms_next = (millisecond_of_day >= MS_PER_DAY) ? (MS_PER_DAY - 27'd1)
                                                     : millisecond_of_day;
    end

    // ---------------- date path ----------------
    // each divide: reciprocal estimate (never high, at most one low), multiply back,
    // then one compare and correct
    always_comb
    begin
        // s2: alpha estimate
        q1_prod  = n1_reg[0] * ALPHA_RECIP;
        q1e_next = q1_prod[N1_BITS+6:N1_BITS];
        // s3: multiply back
        t1_full  = q1e_reg[0] * ALPHA_DIV;
        t1_next  = t1_full[N1_BITS-1:0];
        // s4: correct
        r1          = n1_reg[2] - t1_reg;
        alpha8_next = q1e_reg[1] + 7'(r1 >= N1_BITS'(ALPHA_DIV));
        // s5: b = z + 1 + alpha - floor(alpha / 4) + 1524, with alpha + 8 in hand
        b_next = z_reg[3] + B_BIAS + 23'(alpha8_next_hold(alpha8_reg));
        // s6
        n2_next = 27'(27'(b_reg[0]) * 27'd20 - C_BIAS);
        // s7
        q2_prod  = n2_reg[0] * C_RECIP;
        q2e_next = q2_prod[40:27];
        // s8
        t2_next = q2e_reg[0] * C_DIV;
        // s9
        r2     = n2_reg[2] - t2_reg;
        c_next = q2e_reg[1] + 14'(r2 >= 27'(C_DIV));
        // s10: d = floor(1461 c / 4)
        d_full = c_reg[0] * D_MUL;
        d_next = d_full[24:2];
        // s11: day of the March-based year, offset by 122
        bd_next = 9'(b_reg[5] - d_reg);
        // s12
        n4_next = bd_reg[0] * E_SCALE;
        // s13
        q4_prod  = n4_reg[0] * E_RECIP;
        q4e_next = q4_prod[27:23];
        // s14
        t4_next = q4e_reg[0] * E_DIV;
        // s15
        r4     = 24'(n4_reg[2]) - t4_reg;
        e_next = q4e_reg[1] + 5'(r4 >= 24'(E_DIV));
    end

    // final date fields from e, the day count and c
    always_comb
    begin
        day_next   = 5'(bd_reg[4] - month_start(e_reg));
        month_next = (e_reg < 5'd14) ? 4'(e_reg - 5'd1) : 4'(e_reg - 5'd13);
        year_next  = (month_next > 4'd2) ? (c_reg[6] - YEAR_OFS_LATE)
                                         : (c_reg[6] - YEAR_OFS_EARLY);
    end

    // ---------------- time path ----------------
    always_comb
    begin
        // s2: hour estimate
        hq_prod = ms_reg[0] * HOUR_RECIP;
        hq_next = hq_prod[31:27];
        // s3
        th_next = hq_reg[0] * MS_PER_HOUR;
        // s4: hour and remainder within the hour
        rh_raw    = ms_reg[2] - th_reg;
        rh_fix    = rh_raw >= 27'(MS_PER_HOUR);
        hour_next = hq_reg[1] + 5'(rh_fix);
        rh_next   = rh_fix ? 22'(rh_raw - 27'(MS_PER_HOUR)) : rh_raw[21:0];
        // s5: minute estimate
        mq_prod = rh_reg[0] * MINUTE_RECIP;
        mq_next = mq_prod[27:22];
        // s6
        tm_next = mq_reg[0] * MS_PER_MINUTE;
        // s7: minute and remainder within the minute
        rm_raw      = rh_reg[2] - tm_reg;
        rm_fix      = rm_raw >= 22'(MS_PER_MINUTE);
        minute_next = mq_reg[1] + 6'(rm_fix);
        rm_next     = rm_fix ? 16'(rm_raw - 22'(MS_PER_MINUTE)) : rm_raw[15:0];
        // s8: second estimate
        sq_prod = rm_reg[0] * SECOND_RECIP;
        sq_next = sq_prod[21:16];
        // s9
        ts_next = sq_reg[0] * MS_PER_SECOND;
        // s10: second and millisecond
        rs_raw               = rm_reg[2] - ts_reg;
        rs_fix               = rs_raw >= 16'(MS_PER_SECOND);
        tod_next.hour        = hour_reg[5];
        tod_next.minute      = minute_reg[2];
        tod_next.second      = sq_reg[1] + 6'(rs_fix);
        tod_next.millisecond = rs_fix ? 10'(rs_raw - 16'(MS_PER_SECOND)) : rs_raw[9:0];
    end

    // ---------------- control: valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[STAGES-2:0], start};
            done_reg <= vld_reg[STAGES-1];
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        ok_reg <= {ok_reg[STAGES-2:0], ok_next};

        z_reg[0] <= z_next;
        for (int i = 1; i < 4; i++)
        begin
            z_reg[i] <= z_reg[i-1];
        end
        n1_reg[0]  <= n1_next;
        n1_reg[1]  <= n1_reg[0];
        n1_reg[2]  <= n1_reg[1];
        q1e_reg[0] <= q1e_next;
        q1e_reg[1] <= q1e_reg[0];
        t1_reg     <= t1_next;
        alpha8_reg <= alpha8_next;

        b_reg[0] <= b_next;
        for (int i = 1; i < 6; i++)
        begin
            b_reg[i] <= b_reg[i-1];
        end
        n2_reg[0]  <= n2_next;
        n2_reg[1]  <= n2_reg[0];
        n2_reg[2]  <= n2_reg[1];
        q2e_reg[0] <= q2e_next;
        q2e_reg[1] <= q2e_reg[0];
        t2_reg     <= t2_next;

        c_reg[0] <= c_next;
        for (int i = 1; i < 7; i++)
        begin
            c_reg[i] <= c_reg[i-1];
        end
        d_reg <= d_next;

        bd_reg[0] <= bd_next;
        for (int i = 1; i < 5; i++)
        begin
            bd_reg[i] <= bd_reg[i-1];
        end
        n4_reg[0]  <= n4_next;
        n4_reg[1]  <= n4_reg[0];
        n4_reg[2]  <= n4_reg[1];
        q4e_reg[0] <= q4e_next;
        q4e_reg[1] <= q4e_reg[0];
        t4_reg     <= t4_next;
        e_reg      <= e_next;

        ms_reg[0] <= ms_next;
        ms_reg[1] <= ms_reg[0];
        ms_reg[2] <= ms_reg[1];
        hq_reg[0] <= hq_next;
        hq_reg[1] <= hq_reg[0];
        th_reg    <= th_next;

        hour_reg[0] <= hour_next;
        for (int i = 1; i < 6; i++)
        begin
            hour_reg[i] <= hour_reg[i-1];
        end
        rh_reg[0] <= rh_next;
        rh_reg[1] <= rh_reg[0];
        rh_reg[2] <= rh_reg[1];
        mq_reg[0] <= mq_next;
        mq_reg[1] <= mq_reg[0];
        tm_reg    <= tm_next;

        minute_reg[0] <= minute_next;
        minute_reg[1] <= minute_reg[0];
        minute_reg[2] <= minute_reg[1];
        rm_reg[0]     <= rm_next;
        rm_reg[1]     <= rm_reg[0];
        rm_reg[2]     <= rm_reg[1];
        sq_reg[0]     <= sq_next;
        sq_reg[1]     <= sq_reg[0];
        ts_reg        <= ts_next;

        tod_reg[0] <= tod_next;
        for (int i = 1; i < 6; i++)
        begin
            tod_reg[i] <= tod_reg[i-1];
        end

        // output register; out-of-range years clear every field
        if (vld_reg[STAGES-1])
        begin
            if (ok_reg[STAGES-1])
            begin
                year_reg     <= year_next;
                month_reg    <= month_next;
                day_reg      <= day_next;
                tod_out_reg  <= tod_reg[5];
                in_range_reg <= 1'b1;
            end
            else
            begin
                year_reg     <= '0;
                month_reg    <= '0;
                day_reg      <= '0;
                tod_out_reg  <= '0;
                in_range_reg <= 1'b0;
            end
        end
    end

    // ---------------- ports ----------------
    assign busy         = 1'b0;
    assign done         = done_reg;
    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = day_reg;
    assign hour         = tod_out_reg.hour;
    assign minute       = tod_out_reg.minute;
    assign second       = tod_out_reg.second;
    assign millisecond  = tod_out_reg.millisecond;
    assign in_range     = in_range_reg;

endmodule

`default_nettype wire
